/* hdl/kint_pkg.sv */
// ----------------------------------------------------------------------------
// kint_pkg
// Shared types, constants and keyword prefix functions of the tokenizer.
// ----------------------------------------------------------------------------
package kint_pkg;

  localparam int OFFSET_BITS   = 16;
  localparam int MAX_TOKEN_LEN = 255;
  localparam int LEN_BITS      = $clog2(MAX_TOKEN_LEN + 1);
  localparam int FIFO_DEPTH    = 4;
  localparam int PTR_BITS      = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_EOT    = 8'h00;
  localparam logic [7:0] CH_ASSIGN = "=";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_I      = "i";
  localparam logic [7:0] CH_N      = "n";
  localparam logic [7:0] CH_T      = "t";
  localparam logic [7:0] CH_P      = "p";
  localparam logic [7:0] CH_R      = "r";

  typedef enum logic [3:0] {
    TK_EOF    = 4'd0,
    TK_INT    = 4'd1,
    TK_PRINT  = 4'd2,
    TK_IDENT  = 4'd3,
    TK_NUMBER = 4'd4,
    TK_ASSIGN = 4'd5,
    TK_PLUS   = 4'd6,
    TK_LPAREN = 4'd7,
    TK_RPAREN = 4'd8,
    TK_SEMI   = 4'd9
  } tok_kind_e;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_IDENT  = 2'd1,
    CLS_NUMBER = 2'd2
  } cls_e;

  typedef enum logic [3:0] {
    KW_NONE  = 4'd0,
    KW_I     = 4'd1,
    KW_IN    = 4'd2,
    KW_INT   = 4'd3,
    KW_P     = 4'd4,
    KW_PR    = 4'd5,
    KW_PRI   = 4'd6,
    KW_PRIN  = 4'd7,
    KW_PRINT = 4'd8
  } kw_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] start;
    logic [7:0]  length;
    logic        too_long;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [1:0] num;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic kw_e kw_first(logic [7:0] c);
    kw_e r;
    r = KW_NONE;
    if (c == CH_I) r = KW_I;
    else if (c == CH_P) r = KW_P;
    return r;
  endfunction

  function automatic kw_e kw_next(kw_e s, logic [7:0] c);
    kw_e r;
    r = KW_NONE;
    case (s)
      KW_I:    if (c == CH_N) r = KW_IN;
      KW_IN:   if (c == CH_T) r = KW_INT;
      KW_P:    if (c == CH_R) r = KW_PR;
      KW_PR:   if (c == CH_I) r = KW_PRI;
      KW_PRI:  if (c == CH_N) r = KW_PRIN;
      KW_PRIN: if (c == CH_T) r = KW_PRINT;
      default: r = KW_NONE;
    endcase
    return r;
  endfunction

endpackage

/* hdl/kint_lexer.sv */
// ----------------------------------------------------------------------------
// kint_lexer
// Per-character classification, pending token state and result generation.
// ----------------------------------------------------------------------------
module kint_lexer import kint_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] char_code_i,
  input  logic       fire_i,
  output push_t      res_o
);

  logic [OFFSET_BITS-1:0] pos_q, pos_d, pos_inc;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LEN_BITS-1:0]    len_q, len_d;
  cls_e                   cls_q, cls_d;
  kw_e                    kw_q, kw_d;
  logic                   ovf_q, ovf_d;

  logic      is_letter, is_digit, cont, has_pend, has_new;
  token_t    pend_tok, new_tok;
  tok_kind_e pend_kind;

  always_comb begin
    is_letter = char_code_i inside {["a":"z"], ["A":"Z"]};
    is_digit  = char_code_i inside {["0":"9"]};
    pos_inc   = pos_q + 1'b1;
    cont      = ((cls_q == CLS_IDENT) && (is_letter || is_digit)) ||
                ((cls_q == CLS_NUMBER) && is_digit);

    pend_kind = TK_NUMBER;
    if (cls_q == CLS_IDENT) begin
      pend_kind = TK_IDENT;
      if (!ovf_q && kw_q == KW_INT && len_q == LEN_BITS'(3)) pend_kind = TK_INT;
      if (!ovf_q && kw_q == KW_PRINT && len_q == LEN_BITS'(5)) pend_kind = TK_PRINT;
    end
    pend_tok.kind     = pend_kind;
    pend_tok.start    = 16'(start_q);
    pend_tok.length   = 8'(len_q);
    pend_tok.too_long = ovf_q;
    pend_tok.last     = 1'b0;

    new_tok.kind     = TK_EOF;
    new_tok.start    = 16'(pos_q);
    new_tok.length   = 8'd1;
    new_tok.too_long = 1'b0;
    new_tok.last     = 1'b1;

    pos_d    = pos_q;
    start_d  = start_q;
    len_d    = len_q;
    cls_d    = cls_q;
    kw_d     = kw_q;
    ovf_d    = ovf_q;
    has_pend = 1'b0;
    has_new  = 1'b0;

    if (cont) begin
      pos_d = pos_inc;
      if (len_q >= LEN_BITS'(MAX_TOKEN_LEN)) begin
        ovf_d = 1'b1;
        kw_d  = KW_NONE;
      end else begin
        len_d = len_q + 1'b1;
        kw_d  = kw_next(kw_q, char_code_i);
      end
    end else begin
      if (cls_q != CLS_NONE) begin
        has_pend = 1'b1;
        cls_d    = CLS_NONE;
        len_d    = '0;
        kw_d     = KW_NONE;
        ovf_d    = 1'b0;
      end
      if (char_code_i == CH_EOT) begin
        has_new        = 1'b1;
        new_tok.length = 8'd0;
        pos_d          = '0;
      end else begin
        pos_d = pos_inc;
        if (is_letter || is_digit) begin
          cls_d   = is_letter ? CLS_IDENT : CLS_NUMBER;
          start_d = pos_q;
          len_d   = LEN_BITS'(1);
          ovf_d   = 1'b0;
          kw_d    = is_letter ? kw_first(char_code_i) : KW_NONE;
        end else begin
          has_new = 1'b1;
          case (char_code_i)
            CH_ASSIGN: new_tok.kind = TK_ASSIGN;
            CH_PLUS:   new_tok.kind = TK_PLUS;
            CH_LPAREN: new_tok.kind = TK_LPAREN;
            CH_RPAREN: new_tok.kind = TK_RPAREN;
            CH_SEMI:   new_tok.kind = TK_SEMI;
            default:   has_new = 1'b0;
          endcase
        end
      end
    end

    res_o.num  = {1'b0, has_pend} + {1'b0, has_new};
    res_o.tok1 = new_tok;
    if (has_pend) begin
      res_o.tok0      = pend_tok;
      res_o.tok0.last = !has_new;
    end else begin
      res_o.tok0 = new_tok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      cls_q   <= CLS_NONE;
      kw_q    <= KW_NONE;
      ovf_q   <= 1'b0;
    end else if (fire_i) begin
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      cls_q   <= cls_d;
      kw_q    <= kw_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

/* hdl/kint_fifo.sv */
// ----------------------------------------------------------------------------
// kint_fifo
// Result queue: takes up to two tokens a cycle when push_en_i is set, hands out one a cycle when pop_i is set.
// ----------------------------------------------------------------------------
module kint_fifo import kint_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  push_t               push_i,
  input  logic                push_en_i,
  input  logic                pop_i,
  output logic [CNT_BITS-1:0] free_o,
  output logic                valid_o,
  output token_t              head_o
);

  token_t                mem_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d, push_cnt;

  always_comb begin
    push_cnt = push_en_i ? CNT_BITS'(push_i.num) : '0;
    wr_next  = wr_q + 1'b1;
    wr_d     = wr_q + PTR_BITS'(push_cnt);
    rd_d     = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d    = cnt_q + push_cnt - CNT_BITS'(pop_i);
    free_o   = CNT_BITS'(FIFO_DEPTH) - cnt_q;
    valid_o  = cnt_q != '0;
    head_o   = mem_q[rd_q];
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt != '0) mem_q[wr_q] <= push_i.tok0;
    if (push_cnt == CNT_BITS'(2)) mem_q[wr_next] <= push_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hdl/keyword_ident_number_tokenizer.sv */
// ----------------------------------------------------------------------------
// keyword_ident_number_tokenizer
// Streaming tokenizer: characters in, keyword/identifier/number/punctuation
// tokens out as kind, start offset and length.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  input    in         in_valid_i/in_stall_o  char_code_i
//  output   out        out_valid_o/out_stall_i token_kind_o, start_offset_o,
//                                             token_length_o, too_long_o,
//                                             last_of_run_o
//
// One character is accepted per cycle unless stalled; its first token passes
// the char_q register and a result queue entry before it appears. A character
// closing a token and emitting its own gives two tokens; the four-entry queue
// drains one a cycle unless out_stall_i is high, bounding the sustained rate.
// Reset clears the offset counter and pending token; no clearing pass.
// in_stall_o rises when the queue cannot take the held character's tokens.
// ----------------------------------------------------------------------------
module keyword_ident_number_tokenizer import kint_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] start_offset_o,
  output logic [7:0]  token_length_o,
  output logic        too_long_o,
  output logic        last_of_run_o
);

  logic                valid_q, valid_d, fire, accept, pop;
  logic [7:0]          char_q;
  logic [CNT_BITS-1:0] free;
  push_t               res;
  token_t              head;

  assign fire       = valid_q && (free >= CNT_BITS'(res.num));
  assign in_stall_o = valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept ? 1'b1 : (fire ? 1'b0 : valid_q);
  assign pop        = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) char_q <= char_code_i;
  end

  kint_lexer u_lexer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_code_i (char_q),
    .fire_i      (fire),
    .res_o       (res)
  );

  kint_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (res),
    .push_en_i (fire),
    .pop_i     (pop),
    .free_o    (free),
    .valid_o   (out_valid_o),
    .head_o    (head)
  );

  assign token_kind_o   = 4'(head.kind);
  assign start_offset_o = head.start;
  assign token_length_o = head.length;
  assign too_long_o     = head.too_long;
  assign last_of_run_o  = head.last;

endmodule

/* hdl/kint_checker.sv */
// ----------------------------------------------------------------------------
// kint_checker
// Port-level checks of the tokenizer output, bound to the top level.
// ----------------------------------------------------------------------------
module kint_checker import kint_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  char_code_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  token_kind_o,
  input logic [15:0] start_offset_o,
  input logic [7:0]  token_length_o,
  input logic        too_long_o,
  input logic        last_of_run_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(char_code_i))
    else $error("stalled character changed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(start_offset_o) && $stable(token_length_o) &&
      $stable(too_long_o) && $stable(last_of_run_o))
    else $error("stalled token changed");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= 4'(TK_SEMI))
    else $error("token kind out of range");

  a_eof_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == 4'(TK_EOF) |->
      token_length_o == 8'd0 && !too_long_o && last_of_run_o)
    else $error("bad end-of-file token");

  a_punct_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o >= 4'(TK_ASSIGN) |->
      token_length_o == 8'd1 && !too_long_o && last_of_run_o)
    else $error("bad punctuation token");

endmodule

bind keyword_ident_number_tokenizer kint_checker u_kint_checker (.*);
